// File: hdl/itda_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the integer to decimal ascii converter
package itda_pkg;

    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int NUM_DIGITS  = 10;
    localparam int DIGIT_W     = 4;
    localparam int IDX_W       = 4;
    localparam int CNT_W       = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO    = 8'd48;
    localparam logic [CHAR_W-1:0]  ASCII_MINUS   = 8'd45;
    localparam logic [DIGIT_W-1:0] DABBLE_THRESH = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD    = 4'd3;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX     = 4'd9;
    localparam logic [CNT_W-1:0]   LAST_STEP     = 5'd31;

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

    // one converted number waiting for the emitter
    typedef struct packed {
        logic    negative;
        digits_t digits;
    } num_t;

endpackage

// File: hdl/itda_front.sv
`timescale 1ns / 1ps
// front end: takes a value, forms its magnitude and converts it to bcd bit by bit
module itda_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [itda_pkg::VALUE_W-1:0] s_tdata,
    output logic                         push_valid,
    input  logic                         push_ready,
    output itda_pkg::num_t               push_data
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_DONE
    } fstate_t;

    fstate_t                       state_reg, state_next;
    logic [itda_pkg::VALUE_W-1:0]  mag_reg, mag_next;
    itda_pkg::digits_t             bcd_reg, bcd_next;
    logic                          neg_reg, neg_next;
    logic [itda_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    itda_pkg::digits_t             adj;
    logic [itda_pkg::NUM_DIGITS*itda_pkg::DIGIT_W-1:0] adj_bits;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < itda_pkg::NUM_DIGITS; i++) begin
            adj[i] = (bcd_reg[i] >= itda_pkg::DABBLE_THRESH)
                   ? bcd_reg[i] + itda_pkg::DABBLE_ADD : bcd_reg[i];
        end
    end

    // flat view of the adjusted digits for the one-bit shift
    assign adj_bits = adj;

    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_tvalid) begin
                    neg_next   = s_tdata[itda_pkg::VALUE_W-1];
                    // magnitude in unsigned arithmetic, so the most negative value works
                    mag_next   = s_tdata[itda_pkg::VALUE_W-1]
                               ? ({itda_pkg::VALUE_W{1'b0}} - s_tdata) : s_tdata;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = F_CONV;
                end
            end
            F_CONV: begin
                bcd_next = {adj_bits[itda_pkg::NUM_DIGITS*itda_pkg::DIGIT_W-2:0],
                            mag_reg[itda_pkg::VALUE_W-1]};
                mag_next = {mag_reg[itda_pkg::VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == itda_pkg::LAST_STEP) begin
                    state_next = F_DONE;
                end
            end
            F_DONE: begin
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    assign s_tready           = (state_reg == F_IDLE);
    assign push_valid         = (state_reg == F_DONE);
    assign push_data.negative = neg_reg;
    assign push_data.digits   = bcd_reg;

endmodule

// File: hdl/itda_fifo.sv
`timescale 1ns / 1ps
// short queue of converted numbers between front end and emitter
module itda_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  itda_pkg::num_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output itda_pkg::num_t rd_data
);

    itda_pkg::num_t               mem [itda_pkg::QUEUE_DEPTH];
    logic [itda_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [itda_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [itda_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic                         do_wr, do_rd;

    assign wr_ready = (count_reg != itda_pkg::QCNT_W'(itda_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: hdl/itda_back.sv
`timescale 1ns / 1ps
// back end: emits sign and digits of one number, one character per transfer
module itda_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  itda_pkg::num_t              q_data,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [itda_pkg::CHAR_W-1:0] m_tdata,
    output logic                        m_tlast
);

    typedef enum logic {
        B_IDLE,
        B_EMIT
    } bstate_t;

    bstate_t                      state_reg, state_next;
    itda_pkg::digits_t            digits_reg, digits_next;
    logic                         neg_reg, neg_next;
    logic [itda_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [itda_pkg::CHAR_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                         m_tlast_reg, m_tlast_next;
    logic [itda_pkg::DIGIT_W-1:0] cur_digit;
    logic                         slot_free;

    // highest nonzero digit, zero when the whole number is zero
    function automatic logic [itda_pkg::IDX_W-1:0] top_index(input itda_pkg::digits_t d);
        logic [itda_pkg::IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < itda_pkg::NUM_DIGITS; i++) begin
            if (d[i] != '0) begin
                r = itda_pkg::IDX_W'(i);
            end
        end
        return r;
    endfunction

    assign cur_digit = digits_reg[idx_reg];
    assign slot_free = !m_tvalid_reg || m_tready;
    assign q_ready   = (state_reg == B_IDLE);

    always_comb begin
        state_next    = state_reg;
        digits_next   = digits_reg;
        neg_next      = neg_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    digits_next = q_data.digits;
                    neg_next    = q_data.negative;
                    idx_next    = top_index(q_data.digits);
                    state_next  = B_EMIT;
                end
            end
            B_EMIT: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    if (neg_reg) begin
                        m_tdata_next = itda_pkg::ASCII_MINUS;
                        m_tlast_next = 1'b0;
                        neg_next     = 1'b0;
                    end else begin
                        m_tdata_next = itda_pkg::ASCII_ZERO
                                     + {{(itda_pkg::CHAR_W-itda_pkg::DIGIT_W){1'b0}}, cur_digit};
                        m_tlast_next = (idx_reg == '0);
                        if (idx_reg == '0) begin
                            state_next = B_IDLE;
                        end else begin
                            idx_next = idx_reg - 1'b1;
                        end
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        digits_reg  <= digits_next;
        neg_reg     <= neg_next;
        idx_reg     <= idx_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg == itda_pkg::ASCII_MINUS) |-> !m_tlast_reg)
        else $error("sign character flagged as last");

    a_last_is_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tlast_reg) |->
        (m_tdata_reg >= itda_pkg::ASCII_ZERO &&
         m_tdata_reg <= itda_pkg::ASCII_ZERO + 8'(itda_pkg::DIGIT_MAX)))
        else $error("last character is not a digit");

    a_digit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_EMIT && !neg_reg) |->
        (cur_digit <= itda_pkg::DIGIT_MAX && idx_reg < itda_pkg::IDX_W'(itda_pkg::NUM_DIGITS)))
        else $error("emitter addressing a bad bcd digit");
`endif

endmodule

// File: hdl/int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// front end: a load state, 32 shift-add-3 steps, then a hand-off state that waits for queue space
// back end: one character per cycle while m_tready allows, 1 to 11 characters per number, plus a load state
// sustained rate: set by the bit-serial bcd conversion loop, which takes a new value only after the last is handed off
// reset: synchronous active-low aresetn clears control state; the queue comes up empty
module int_to_decimal_ascii (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input channel
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [itda_pkg::VALUE_W-1:0] s_tdata,   // [31:0] value, two's complement
    // result channel
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [itda_pkg::CHAR_W-1:0]  m_tdata,   // [7:0] character, ascii
    output logic                         m_tlast    // final character of the number
);

    // converted numbers flowing from front end into the queue
    logic           push_valid;
    logic           push_ready;
    itda_pkg::num_t push_data;

    // queue head offered to the emitter
    logic           q_valid;
    logic           q_ready;
    itda_pkg::num_t q_data;

    // sign and magnitude, then double dabble into ten bcd digits
    itda_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // lets the front end start the next number while characters still drain
    itda_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    // leading zero suppression and character output register
    itda_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: bench/int_to_decimal_ascii_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the integer to decimal ascii converter
module int_to_decimal_ascii_tb;

    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          HOLD_CYCLES  = 600;
    localparam int          TAIL_CYCLES  = 60;
    localparam int          PHASE_ITEMS  = 80;
    localparam int          RADIX        = 10;
    localparam int unsigned INT_MAX_MAG  = 32'd2147483647;

    // one character transfer as seen on the result channel
    typedef struct packed {
        logic [itda_pkg::CHAR_W-1:0] character;
        logic                        last;
    } char_beat_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [itda_pkg::VALUE_W-1:0]  s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [itda_pkg::CHAR_W-1:0]   m_tdata;
    logic                          m_tlast;

    logic [itda_pkg::VALUE_W-1:0]  number_queue[$];
    char_beat_t          expected_chars[$];
    int                  idle_pct   = 0;
    int                  stall_pct  = 0;
    bit                  rx_hold    = 1'b0;
    bit                  hold_go    = 1'b0;
    int                  errors     = 0;
    int                  cycle_count = 0;

    // extremes, digit-count boundaries and alternating bit patterns
    logic [itda_pkg::VALUE_W-1:0] directed_set [20] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
        -32'sd5, 32'd123456789, -32'sd987654321, 32'd999999999, 32'd1000000000,
        -32'sd1000000000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
        32'h5555_5555, 32'hAAAA_AAAA, 32'd1000000
    };

    int_to_decimal_ascii i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // decimal text of one number: sign first, then digits from the most significant
    function automatic void predict_text(input logic [itda_pkg::VALUE_W-1:0] value);
        logic [itda_pkg::VALUE_W-1:0] mag;
        logic [itda_pkg::DIGIT_W-1:0] digit_buf [itda_pkg::NUM_DIGITS];
        int                           n_dig;
        char_beat_t                   beat;
        // magnitude in unsigned 32-bit arithmetic, so the most negative value works
        mag = value[itda_pkg::VALUE_W-1] ? (32'd0 - value) : value;
        n_dig = 0;
        do begin
            digit_buf[n_dig] = itda_pkg::DIGIT_W'(mag % RADIX);
            mag = mag / RADIX;
            n_dig++;
        end while (mag != 0);
        if (value[itda_pkg::VALUE_W-1]) begin
            beat.character = itda_pkg::ASCII_MINUS;
            beat.last      = 1'b0;
            expected_chars.push_back(beat);
        end
        for (int k = n_dig - 1; k >= 0; k--) begin
            beat.character = itda_pkg::ASCII_ZERO + itda_pkg::CHAR_W'(digit_buf[k]);
            beat.last      = (k == 0);
            expected_chars.push_back(beat);
        end
    endfunction

    // mostly numbers of a chosen digit count, some raw words, small values and values near the ends
    function automatic logic [itda_pkg::VALUE_W-1:0] random_value();
        int                           pick;
        int                           n_dig;
        longint                       lo;
        longint                       hi;
        logic [itda_pkg::VALUE_W-1:0] mag;
        bit                           neg;
        pick = $urandom_range(0, 9);
        neg  = $urandom_range(0, 1);
        if (pick < 2) begin
            return $urandom;
        end else if (pick < 4) begin
            mag = $urandom_range(0, 20);
        end else if (pick < 9) begin
            n_dig = $urandom_range(1, itda_pkg::NUM_DIGITS);
            lo = 1;
            repeat (n_dig - 1) lo = lo * RADIX;
            hi = lo * RADIX - 1;
            if (n_dig == 1) lo = 0;
            if (hi > INT_MAX_MAG) hi = INT_MAX_MAG;
            mag = $urandom_range(int'(hi), int'(lo));
        end else begin
            return neg ? (32'h8000_0000 + $urandom_range(0, 5))
                       : (32'h7FFF_FFFF - $urandom_range(0, 5));
        end
        return neg ? (32'd0 - mag) : mag;
    endfunction

    // driver: holds each value until its transfer, then may rest before offering the next
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_text(s_tdata);
            end
            if (!s_tvalid || s_tready) begin
                if (number_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= number_queue.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks every character transfer against the oldest expectation
    always @(posedge aclk) begin
        char_beat_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    $error("character %0d with no number pending", m_tdata);
                    errors++;
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata !== want.character) begin
                        $error("character: expected %0d, got %0d", want.character, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_tlast);
                        errors++;
                    end
                end
            end
            m_tready <= !rx_hold && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // long receiver hold-off, counted here so the input side backs up
    initial begin
        int hold_n;
        wait (hold_go);
        @(negedge aclk);
        rx_hold = 1'b1;
        for (hold_n = 0; hold_n < HOLD_CYCLES; hold_n++) @(negedge aclk);
        rx_hold = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[int_to_decimal_ascii] ERROR");
            $finish;
        end
    end

    // wait until every value has gone in and every character has come out
    task automatic wait_drained();
        while (number_queue.size() != 0 || s_tvalid || expected_chars.size() != 0)
            @(negedge aclk);
    endtask

    task automatic run_phase(input int n_items, input int idle, input int stall);
        @(negedge aclk);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (n_items) number_queue.push_back(random_value());
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed values, no idling
        @(negedge aclk);
        foreach (directed_set[i]) number_queue.push_back(directed_set[i]);
        wait_drained();

        run_phase(PHASE_ITEMS, 0, 0);
        run_phase(PHASE_ITEMS, 68, 0);
        run_phase(PHASE_ITEMS, 0, 68);
        run_phase(PHASE_ITEMS, 9, 9);

        // backpressure: sender keeps offering while the receiver holds off
        @(negedge aclk);
        idle_pct  = 0;
        stall_pct = 0;
        hold_go   = 1'b1;
        repeat (30) number_queue.push_back(random_value());
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge aclk);
        if (errors == 0 && expected_chars.size() == 0) begin
            $display("[int_to_decimal_ascii] OK");
        end else begin
            $display("[int_to_decimal_ascii] ERROR");
        end
        $finish;
    end

endmodule
